>>> hw/rtl/rpa_pkg.sv
// Shared types and constants for the repetition-penalised argmax block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rpa_pkg;

	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int SCORE_WIDTH_DEF   = 32;

	localparam int CMD_W       = 2;
	localparam int ID_W        = 32;
	localparam int LOGIT_W     = 32;
	localparam int OUT_SCORE_W = 32;
	localparam int PEN_W       = 16;
	localparam int RECIP_W     = 24;
	localparam int LOOKBACK_W  = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	// 1.0 in Q8.8: no penalty applied
	localparam logic [PEN_W-1:0]      PENALTY_ONE    = 16'd256;
	localparam logic [RECIP_W-1:0]    RECIP_RESET    = 24'd65536;
	localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 7'd64;

	// most negative logit stands for minus infinity
	localparam logic signed [LOGIT_W-1:0] LOGIT_MINF = 32'sh8000_0000;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_CAND  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PENALTY  = 2'd0,
		CFG_RECIP    = 2'd1,
		CFG_LOOKBACK = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCORE,
		ST_UPDATE
	} state_t;

	// history chain control for each accepted transaction
	typedef struct packed {
		logic clear;
		logic push;
		logic compare;
	} hist_ctl_t;

endpackage

>>> hw/rtl/rpa_item_if.sv
// Input channel: command, token id, logit and last flag with valid/ready.
// Depends on rpa_pkg for field widths.
`timescale 1ns / 1ps

interface rpa_item_if import rpa_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [ID_W-1:0]    token_id;
	logic signed [LOGIT_W-1:0] logit;
	logic                      last;

	modport source (output valid, command, token_id, logit, last, input ready);
	modport sink (input valid, command, token_id, logit, last, output ready);

endinterface

>>> hw/rtl/rpa_result_if.sv
// Result channel: chosen id, chosen score and status with valid/ready.
// Depends on rpa_pkg for field widths.
`timescale 1ns / 1ps

interface rpa_result_if import rpa_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic signed [ID_W-1:0]        chosen_id;
	logic signed [OUT_SCORE_W-1:0] chosen_score;
	logic                          status;

	modport source (output valid, chosen_id, chosen_score, status, input ready);
	modport sink (input valid, chosen_id, chosen_score, status, output ready);

endinterface

>>> hw/rtl/rpa_cell.sv
// One history cell: holds a token id, passes it to its neighbour on a push
// and compares it with the candidate id. Depends on rpa_pkg.
`timescale 1ns / 1ps

module rpa_cell import rpa_pkg::*; #(
	parameter int INDEX = 0,
	parameter int WIN_W = LOOKBACK_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   compare,
	input  logic signed [ID_W-1:0] d,
	input  logic signed [ID_W-1:0] cand_id,
	input  logic [WIN_W-1:0]       win,
	output logic signed [ID_W-1:0] q,
	output logic                   match
);

	logic signed [ID_W-1:0] entry_q;
	logic                   match_q;

	always_ff @(posedge clk) begin
		if (shift)
			entry_q <= d;
	end

	// only cells inside the lookback window may report a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (compare) begin
			match_q <= (entry_q == cand_id) && (WIN_W'(INDEX) < win);
		end
	end

	assign q     = entry_q;
	assign match = match_q;

endmodule

>>> hw/rtl/rpa_hist.sv
// History shift chain of rpa_cell instances with fill count and hit reduction.
// Depends on rpa_pkg and rpa_cell.
`timescale 1ns / 1ps

module rpa_hist import rpa_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hist_ctl_t              ctl,
	input  logic signed [ID_W-1:0] token_id,
	input  logic [LOOKBACK_W-1:0]  lookback,
	output logic                   hit
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int WIN_W = (CNT_W > LOOKBACK_W) ? CNT_W : LOOKBACK_W;

	logic [CNT_W-1:0]       cnt_q;
	logic [WIN_W-1:0]       lb_ext;
	logic [WIN_W-1:0]       cnt_ext;
	logic [WIN_W-1:0]       win;
	logic                   hit_q;
	logic signed [ID_W-1:0] chain_d [HISTORY_DEPTH];
	logic signed [ID_W-1:0] entry [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] match;

	assign lb_ext  = WIN_W'(lookback);
	assign cnt_ext = WIN_W'(cnt_q);
	assign win     = (lb_ext < cnt_ext) ? lb_ext : cnt_ext;

	// entries beyond the fill count are never inside the window,
	// so a clear only resets the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.push && (cnt_q != CNT_W'(HISTORY_DEPTH))) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign chain_d[0] = token_id;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign chain_d[i] = entry[i-1];
		end
		rpa_cell #(
			.INDEX (i),
			.WIN_W (WIN_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (ctl.push),
			.compare (ctl.compare),
			.d       (chain_d[i]),
			.cand_id (token_id),
			.win     (win),
			.q       (entry[i]),
			.match   (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= |match;
		end
	end

	assign hit = hit_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	a_hit_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(win != '0, 2))
		else $error("hit raised with an empty window");

endmodule

>>> hw/rtl/rpa_score.sv
// Penalty scorer: signed multiply by penalty or reciprocal, then shift,
// saturation and minus-infinity handling. Depends on rpa_pkg.
`timescale 1ns / 1ps

module rpa_score import rpa_pkg::*; #(
	parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          mul_en,
	input  logic                          score_en,
	input  logic signed [LOGIT_W-1:0]     logit,
	input  logic [PEN_W-1:0]              penalty_q8,
	input  logic [RECIP_W-1:0]            penalty_recip_q16,
	input  logic                          hit,
	output logic signed [SCORE_WIDTH-1:0] score
);

	localparam int PROD_W = LOGIT_W + RECIP_W + 1;
	// penalised values stay within 41 signed bits
	localparam int EXT_W  = (SCORE_WIDTH + 1 > 42) ? SCORE_WIDTH + 1 : 42;
	localparam logic signed [EXT_W-1:0] SMAX = (EXT_W'(1) << (SCORE_WIDTH - 1)) - EXT_W'(1);
	localparam logic signed [EXT_W-1:0] SMIN = ~SMAX;

	logic                          is_neg;
	logic [RECIP_W-1:0]            factor;
	logic signed [RECIP_W:0]       factor_s;
	logic signed [PROD_W-1:0]      prod_d;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          neg_s2;
	logic signed [PROD_W-1:0]      shifted;
	logic                          penal;
	logic signed [EXT_W-1:0]       raw;
	logic signed [SCORE_WIDTH-1:0] score_d;
	logic signed [SCORE_WIDTH-1:0] score_s3;

	assign is_neg   = logit[LOGIT_W-1];
	assign factor   = is_neg ? RECIP_W'(penalty_q8) : penalty_recip_q16;
	assign factor_s = signed'({1'b0, factor});
	assign prod_d   = logit * factor_s;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s2 <= prod_d;
			neg_s2  <= is_neg;
		end
	end

	// arithmetic shift floors, which for a negative product is minus the
	// rounded-up magnitude
	assign shifted = neg_s2 ? (prod_s2 >>> 8) : (prod_s2 >>> 16);
	assign penal   = hit && (penalty_q8 != PENALTY_ONE);
	assign raw     = penal ? EXT_W'(shifted) : EXT_W'(logit);

	always_comb begin
		priority if (logit == LOGIT_MINF)
			score_d = SMIN[SCORE_WIDTH-1:0];
		else if (raw > SMAX)
			score_d = SMAX[SCORE_WIDTH-1:0];
		else if (raw < SMIN)
			score_d = SMIN[SCORE_WIDTH-1:0];
		else
			score_d = raw[SCORE_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (score_en)
			score_s3 <= score_d;
	end

	assign score = score_s3;

endmodule

>>> hw/rtl/repetition_penalized_argmax_top.sv
// Repetition-penalised greedy argmax: history chain, scorer, pass control.
// Depends on rpa_pkg, rpa_item_if, rpa_result_if, rpa_hist, rpa_score.
//
// Usage:
//   item (sink): one transaction per command. Clear resets the history and
//   the running pass; push shifts a token id into the newest history cell;
//   candidate scores a token id and logit against the history window.
//   result (source): one transaction per pass, on the candidate with last
//   set, carrying the winning id, its penalised score and a negative-id flag.
//   Configuration: cfg_we/cfg_idx/cfg_wdata, written while the block is idle.
// Timing:
//   Clear and push leave the block ready and may follow back to back.
//   A candidate occupies the block while it passes through compare in the history
//   cells, multiply, saturate, then compare with the running best. The
//   result register is loaded as the final candidate leaves the last step.
//   The single multiplier and best-score register allow one candidate at a time.
// Reset: history empty, pass cleared, registers at their defaults; no
//   clearing sweep is needed, the block is ready straight after reset.
// Stall: the result is held in an output register; further items are taken
//   meanwhile, and a final candidate waits in its last stage until the
//   pending result has been taken.
`timescale 1ns / 1ps

module repetition_penalized_argmax_top import rpa_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SCORE_WIDTH   = SCORE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rpa_item_if.sink              item,
	rpa_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int OUT_W = (SCORE_WIDTH > OUT_SCORE_W) ? SCORE_WIDTH : OUT_SCORE_W;
	localparam logic signed [SCORE_WIDTH-1:0] BEST_RESET = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

	logic [PEN_W-1:0]      penalty_q;
	logic [RECIP_W-1:0]    recip_q;
	logic [LOOKBACK_W-1:0] lookback_q;

	state_t    state_q, state_d;
	hist_ctl_t ctl;
	logic      accept;
	logic      cand_acc;
	logic      ready;
	logic      mul_en;
	logic      score_en;
	logic      fire;
	logic      upd;
	logic      hit;

	logic signed [ID_W-1:0]        cand_id_q;
	logic signed [LOGIT_W-1:0]     cand_logit_q;
	logic                          cand_last_q;
	logic signed [SCORE_WIDTH-1:0] score;

	logic signed [SCORE_WIDTH-1:0] best_score_q;
	logic signed [ID_W-1:0]        best_id_q;
	logic                          started_q;
	logic                          take;
	logic signed [SCORE_WIDTH-1:0] nb_score;
	logic signed [ID_W-1:0]        nb_id;
	logic signed [OUT_W-1:0]       nb_wide;

	logic                          out_valid_q;
	logic signed [ID_W-1:0]        out_id_q;
	logic signed [OUT_SCORE_W-1:0] out_score_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q  <= PENALTY_ONE;
			recip_q    <= RECIP_RESET;
			lookback_q <= LOOKBACK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_PENALTY:  penalty_q  <= cfg_wdata[PEN_W-1:0];
				CFG_RECIP:    recip_q    <= cfg_wdata[RECIP_W-1:0];
				CFG_LOOKBACK: lookback_q <= cfg_wdata[LOOKBACK_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = item.valid && ready;

	always_comb begin
		ctl      = '0;
		cand_acc = 1'b0;
		if (accept) begin
			unique case (cmd_t'(item.command))
				CMD_CLEAR: ctl.clear = 1'b1;
				CMD_PUSH:  ctl.push  = 1'b1;
				CMD_CAND: begin
					ctl.compare = 1'b1;
					cand_acc    = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cand_acc) begin
			cand_id_q    <= item.token_id;
			cand_logit_q <= item.logit;
			cand_last_q  <= item.last;
		end
	end

	// a final candidate may only retire into a free output register
	assign fire = !cand_last_q || !out_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cand_acc) state_d = ST_MUL;
			ST_MUL:    state_d = ST_SCORE;
			ST_SCORE:  state_d = ST_UPDATE;
			ST_UPDATE: if (fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready    = (state_q == ST_IDLE);
		mul_en   = (state_q == ST_MUL);
		score_en = (state_q == ST_SCORE);
		upd      = (state_q == ST_UPDATE) && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	rpa_hist #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.token_id (item.token_id),
		.lookback (lookback_q),
		.hit      (hit)
	);

	rpa_score #(
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_score (
		.clk               (clk),
		.mul_en            (mul_en),
		.score_en          (score_en),
		.logit             (cand_logit_q),
		.penalty_q8        (penalty_q),
		.penalty_recip_q16 (recip_q),
		.hit               (hit),
		.score             (score)
	);

	// first candidate always taken, later ones only when strictly greater
	assign take     = !started_q || (score > best_score_q);
	assign nb_score = take ? score : best_score_q;
	assign nb_id    = take ? cand_id_q : best_id_q;
	assign nb_wide  = OUT_W'(nb_score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= BEST_RESET;
			best_id_q    <= '0;
			started_q    <= 1'b0;
		end else if (ctl.clear || (upd && cand_last_q)) begin
			best_score_q <= BEST_RESET;
			best_id_q    <= '0;
			started_q    <= 1'b0;
		end else if (upd) begin
			best_score_q <= nb_score;
			best_id_q    <= nb_id;
			started_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd && cand_last_q) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && cand_last_q) begin
			out_id_q    <= nb_id;
			out_score_q <= nb_wide[OUT_SCORE_W-1:0];
		end
	end

	assign item.ready          = ready;
	assign result.valid        = out_valid_q;
	assign result.chosen_id    = out_id_q;
	assign result.chosen_score = out_score_q;
	assign result.status       = out_id_q[ID_W-1];

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPDATE && cand_last_q))
		else $error("result raised without a final candidate");

	a_stall_holds_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !fire) |=>
			(state_q == ST_UPDATE && $stable(best_score_q) && $stable(started_q)))
		else $error("running best changed while the result was stalled");

	a_pass_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && fire && cand_last_q) |=> (!started_q && out_valid_q))
		else $error("pass not closed after the final candidate");

endmodule

>>> bench/repetition_penalized_argmax_top_tb.sv
// Self-checking bench for repetition_penalized_argmax_top: directed and random passes
// against an in-bench scoring model. Needs rpa_pkg, rpa_item_if, rpa_result_if and the RTL.
`timescale 1ns / 1ps

module repetition_penalized_argmax_top_tb;
	import rpa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam longint SCORE_HI = 64'sd2147483647;
	localparam longint SCORE_LO = -64'sd2147483648;
	localparam logic signed [31:0] ID_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] ID_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] LOGIT_TOP = 32'sh7fff_ffff;
	localparam int GAP_MAX = 18;
	localparam int SETTLE_CYCLES = 10;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		logic signed [ID_W-1:0]        id;
		logic signed [OUT_SCORE_W-1:0] score;
		logic                          status;
	} choice_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rpa_item_if item_if ();
	rpa_result_if result_if ();

	repetition_penalized_argmax_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// scoring model state
	logic [PEN_W-1:0]       pen_q8;
	logic [RECIP_W-1:0]     recip_q16;
	logic [LOOKBACK_W-1:0]  window_len;
	logic signed [ID_W-1:0] hist_ids [HISTORY_DEPTH_DEF];
	int                     hist_fill;
	longint                 run_best_score;
	logic signed [ID_W-1:0] run_best_id;
	bit                     run_open;

	choice_t pending_choices [$];
	int      mismatches;
	int      items_accepted;
	bit      calm_sender;
	bit      calm_receiver;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int draw_gap(bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic longint penalised_score(logic signed [ID_W-1:0] id,
			logic signed [LOGIT_W-1:0] logit);
		longint v;
		longint mag;
		int win;
		bit hit;
		if (logit == LOGIT_MINF)
			return SCORE_LO;
		win = (int'(window_len) < hist_fill) ? int'(window_len) : hist_fill;
		hit = 1'b0;
		for (int i = 0; i < win; i++)
			if (hist_ids[i] == id)
				hit = 1'b1;
		v = longint'(logit);
		if (hit && pen_q8 != PENALTY_ONE) begin
			if (v < 0) begin
				// magnitude rounded up, i.e. floor of the negative product
				mag = (-v) * longint'(pen_q8);
				v = -((mag + 255) >>> 8);
			end else begin
				v = (v * longint'(recip_q16)) >>> 16;
			end
		end
		if (v > SCORE_HI)
			return SCORE_HI;
		if (v < SCORE_LO)
			return SCORE_LO;
		return v;
	endfunction

	function automatic void track_item(logic [CMD_W-1:0] cmd, logic signed [ID_W-1:0] id,
			logic signed [LOGIT_W-1:0] logit, logic is_last);
		longint s;
		choice_t c;
		case (cmd)
			CMD_CLEAR: begin
				foreach (hist_ids[i])
					hist_ids[i] = '0;
				hist_fill = 0;
				run_best_score = SCORE_LO;
				run_best_id = '0;
				run_open = 1'b0;
			end
			CMD_PUSH: begin
				for (int i = HISTORY_DEPTH_DEF - 1; i > 0; i--)
					hist_ids[i] = hist_ids[i-1];
				hist_ids[0] = id;
				if (hist_fill < HISTORY_DEPTH_DEF)
					hist_fill++;
			end
			CMD_CAND: begin
				s = penalised_score(id, logit);
				if (!run_open || s > run_best_score) begin
					run_best_score = s;
					run_best_id = id;
					run_open = 1'b1;
				end
				if (is_last) begin
					c.id = run_best_id;
					c.score = run_best_score[31:0];
					c.status = run_best_id[ID_W-1];
					pending_choices.insert(pending_choices.size(), c);
					run_best_score = SCORE_LO;
					run_best_id = '0;
					run_open = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [ID_W-1:0] id,
			logic signed [LOGIT_W-1:0] logit, logic is_last);
		int gap;
		gap = draw_gap(calm_sender);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.command <= cmd;
		item_if.token_id <= id;
		item_if.logit <= logit;
		item_if.last <= is_last;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		track_item(cmd, id, logit, is_last);
		if (cmd != CMD_UNUSED)
			items_accepted++;
	endtask

	// sender holds off until every expected result is in and the pipeline has emptied
	task automatic wait_drained();
		item_if.valid <= 1'b0;
		while (pending_choices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_regs(logic [PEN_W-1:0] pen, logic [RECIP_W-1:0] recip,
			logic [LOOKBACK_W-1:0] lb);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_idx <= CFG_PENALTY;
		cfg_wdata <= CFG_DATA_W'(pen);
		@(posedge clk);
		cfg_idx <= CFG_RECIP;
		cfg_wdata <= recip;
		@(posedge clk);
		cfg_idx <= CFG_LOOKBACK;
		cfg_wdata <= CFG_DATA_W'(lb);
		@(posedge clk);
		cfg_we <= 1'b0;
		pen_q8 = pen;
		recip_q16 = recip;
		window_len = lb;
	endtask

	function automatic logic signed [ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? ID_MAX : ID_MIN;
			default: return int'($urandom_range(0, 15)) - 4;
		endcase
	endfunction

	function automatic logic signed [LOGIT_W-1:0] pick_logit();
		case ($urandom_range(0, 9))
			0: return LOGIT_MINF;
			1: return $urandom;
			2: return $urandom_range(0, 1) ? LOGIT_TOP : LOGIT_MINF + 1;
			3: return (int'($urandom_range(0, 2)) - 1) * 65536;
			default: return int'($urandom_range(0, 1048576)) - 524288;
		endcase
	endfunction

	// result side: random stall per transaction, then check against the oldest expectation
	initial begin
		int stall;
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(calm_receiver);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			@(posedge clk);
			while (!result_if.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		choice_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_choices.size() == 0) begin
				$display("%0t: unexpected result: expected none, got id %0d score %0d status %0b",
					$time, result_if.chosen_id, result_if.chosen_score, result_if.status);
				mismatches++;
			end else begin
				want = pending_choices.pop_front();
				if (result_if.chosen_id !== want.id) begin
					$display("%0t: chosen_id: expected %0d, got %0d",
						$time, want.id, result_if.chosen_id);
					mismatches++;
				end
				if (result_if.chosen_score !== want.score) begin
					$display("%0t: chosen_score: expected %0d, got %0d",
						$time, want.score, result_if.chosen_score);
					mismatches++;
				end
				if (result_if.status !== want.status) begin
					$display("%0t: status: expected %0b, got %0b",
						$time, want.status, result_if.status);
					mismatches++;
				end
			end
		end
	end

	// defaults: penalty 1.0, first maximum wins, minus infinity, negative id flag
	task automatic test_plain_argmax();
		send_item(CMD_PUSH, 5, 0, 1'b0);
		send_item(CMD_CAND, 5, LOGIT_MINF, 1'b0);
		send_item(CMD_CAND, 7, LOGIT_MINF, 1'b0);
		send_item(CMD_CAND, -9, LOGIT_MINF, 1'b1);
		send_item(CMD_CAND, ID_MIN, LOGIT_TOP, 1'b1);
		send_item(CMD_CAND, 3, 65536, 1'b0);
		send_item(CMD_CAND, 4, 65536, 1'b0);
		send_item(CMD_UNUSED, ID_MAX, LOGIT_TOP, 1'b1);
		send_item(CMD_CAND, ID_MAX, -1, 1'b1);
		// a clear in mid-pass drops the running best
		send_item(CMD_CAND, 11, 100, 1'b0);
		send_item(CMD_CLEAR, 0, 0, 1'b0);
		send_item(CMD_CAND, 12, -100, 1'b1);
	endtask

	task automatic test_penalty_cases();
		apply_regs(16'd512, 24'd32768, 7'd64);
		send_item(CMD_CLEAR, 0, 0, 1'b0);
		send_item(CMD_PUSH, 20, 0, 1'b0);
		send_item(CMD_PUSH, 21, 0, 1'b0);
		send_item(CMD_PUSH, -4, 0, 1'b0);
		send_item(CMD_CAND, 20, -3 * 65536, 1'b1);
		send_item(CMD_CAND, 21, 5 * 65536, 1'b0);
		send_item(CMD_CAND, 22, 65536, 1'b1);
		send_item(CMD_CAND, -4, LOGIT_MINF, 1'b1);
		// saturation both ways; window of one keeps only the newest entry
		apply_regs(16'hffff, 24'hff_ffff, 7'd1);
		send_item(CMD_CAND, -4, LOGIT_MINF + 1, 1'b1);
		send_item(CMD_CAND, -4, LOGIT_TOP, 1'b1);
		send_item(CMD_CAND, 20, -1, 1'b1);
		apply_regs(16'd1, 24'd1, 7'd0);
		send_item(CMD_CAND, -4, -5, 1'b1);
		apply_regs(16'd1, 24'd1, 7'd64);
		send_item(CMD_CAND, -4, -1, 1'b1);
		send_item(CMD_CAND, 21, 65535, 1'b1);
	endtask

	// more than a full history: the oldest token falls out of the window
	task automatic test_history_overflow();
		apply_regs(16'd768, 24'd21845, 7'd64);
		send_item(CMD_CLEAR, 0, 0, 1'b0);
		send_item(CMD_PUSH, 1000, 0, 1'b0);
		send_item(CMD_CAND, 1000, -65536, 1'b1);
		repeat (HISTORY_DEPTH_DEF)
			send_item(CMD_PUSH, $urandom_range(2000, 100000), $urandom,
				1'($urandom_range(0, 1)));
		send_item(CMD_CAND, 1000, -65536, 1'b0);
		send_item(CMD_CAND, hist_ids[0], -65536, 1'b0);
		send_item(CMD_CAND, hist_ids[HISTORY_DEPTH_DEF-1], 65536, 1'b1);
	endtask

	task automatic test_random_passes();
		logic [PEN_W-1:0] pen;
		int target;
		int n_push;
		int n_cand;
		int r;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_regs(16'd384, 24'd43690, 7'd64);
				1: apply_regs(16'hffff, 24'd1, 7'd64);
				2: apply_regs(16'd1, 24'hff_ffff, 7'd32);
				3: begin
					pen = PEN_W'($urandom_range(257, 2048));
					apply_regs(pen, 24'((1 << 24) / pen),
						LOOKBACK_W'($urandom_range(1, 64)));
				end
				4: apply_regs(PENALTY_ONE, RECIP_W'($urandom_range(1, 24'hff_ffff)), 7'd64);
				default: apply_regs(PEN_W'($urandom_range(1, 16'hffff)),
					RECIP_W'($urandom_range(1, 24'hff_ffff)), 7'd0);
			endcase
			target = items_accepted + ITEMS_PER_PHASE;
			while (items_accepted < target) begin
				calm_sender = ($urandom_range(0, 3) == 0);
				calm_receiver = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 5) begin
					send_item(CMD_CLEAR, pick_id(), pick_logit(), 1'($urandom_range(0, 1)));
				end else if (r < 9) begin
					send_item(CMD_UNUSED, $urandom, $urandom, 1'($urandom_range(0, 1)));
				end else begin
					n_push = $urandom_range(0, 4);
					n_cand = $urandom_range(1, 8);
					repeat (n_push)
						send_item(CMD_PUSH, pick_id(), $urandom, 1'($urandom_range(0, 1)));
					for (int k = 0; k < n_cand; k++) begin
						// now and then a pass is cut short by a clear
						if (r < 13 && k == n_cand - 1)
							send_item(CMD_CLEAR, pick_id(), pick_logit(), 1'b1);
						else
							send_item(CMD_CAND, pick_id(), pick_logit(), k == n_cand - 1);
					end
				end
				if ($urandom_range(0, 19) == 0)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_PENALTY;
		cfg_wdata <= '0;
		item_if.valid <= 1'b0;
		item_if.command <= CMD_CLEAR;
		item_if.token_id <= '0;
		item_if.logit <= '0;
		item_if.last <= 1'b0;
		pen_q8 = PENALTY_ONE;
		recip_q16 = RECIP_RESET;
		window_len = LOOKBACK_RESET;
		foreach (hist_ids[i])
			hist_ids[i] = '0;
		hist_fill = 0;
		run_best_score = SCORE_LO;
		run_best_id = '0;
		run_open = 1'b0;
		mismatches = 0;
		items_accepted = 0;
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_argmax();
		test_penalty_cases();
		test_history_overflow();
		test_random_passes();

		wait_drained();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
